@@ src/lbh_pkg.sv @@
// lbh_pkg: shared types and constants of the linear bucket histogram
// field widths, opcodes, register indexes and controller states
// no dependencies
package lbh_pkg;

  localparam int OPCODE_W     = 2;
  localparam int INDEX_W      = 8;
  localparam int RESULT_W     = 32;
  localparam int RANGE_LOW_W  = 16;
  localparam int RANGE_HIGH_W = 17;
  localparam int TOTAL_W      = 9;
  localparam int SCALE_W      = 25;
  localparam int FRAC_W       = 16;
  localparam int DIFF_W       = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 25;

  typedef logic [OPCODE_W-1:0]    opcode_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam opcode_t OP_SAMPLE = 2'd0;
  localparam opcode_t OP_READ   = 2'd1;
  localparam opcode_t OP_CLEAR  = 2'd2;
  localparam opcode_t OP_NOP    = 2'd3;

  localparam cfg_index_t CFG_RANGE_LOW  = 2'd0;
  localparam cfg_index_t CFG_RANGE_HIGH = 2'd1;
  localparam cfg_index_t CFG_BIN_TOTAL  = 2'd2;
  localparam cfg_index_t CFG_BIN_SCALE  = 2'd3;

  localparam logic [RANGE_LOW_W-1:0]  RANGE_LOW_RST  = 16'd0;
  localparam logic [RANGE_HIGH_W-1:0] RANGE_HIGH_RST = 17'h10000;
  localparam logic [TOTAL_W-1:0]      BIN_TOTAL_RST  = 9'd256;
  localparam logic [SCALE_W-1:0]      BIN_SCALE_RST  = 25'd256;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN,
    S_RMW,
    S_DONE
  } state_t;

endpackage

@@ src/lbh_bin_map.sv @@
// lbh_bin_map: maps a range offset to a bin number
// registered 16x25 multiply, then shift and clamp to the last active bin
// depends on lbh_pkg
module lbh_bin_map #(
  parameter int BINS = 256
) (
  input  logic                             clk,
  input  logic                             load,
  input  logic [lbh_pkg::DIFF_W-1:0]       diff,
  input  logic [lbh_pkg::SCALE_W-1:0]      scale,
  input  logic [lbh_pkg::TOTAL_W-1:0]      bin_total,
  output logic [$clog2(BINS)-1:0]          bin
);
  import lbh_pkg::*;

  localparam int AW     = $clog2(BINS);
  localparam int PROD_W = DIFF_W + SCALE_W;
  localparam int Q_W    = PROD_W - FRAC_W;

  logic [PROD_W-1:0] prod_r;
  logic [Q_W-1:0]    quot;
  logic [Q_W-1:0]    total_ext;
  logic [Q_W-1:0]    last_bin;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(diff) * PROD_W'(scale);
    end
  end

  assign quot      = prod_r[PROD_W-1:FRAC_W];
  assign total_ext = Q_W'(bin_total);

  // zero bins acts as one bin, too many bins saturate at the storage size
  always_comb begin
    priority if (total_ext == '0) begin
      last_bin = '0;
    end else if (total_ext > Q_W'(BINS)) begin
      last_bin = Q_W'(BINS - 1);
    end else begin
      last_bin = total_ext - Q_W'(1);
    end
  end

  assign bin = (quot > last_bin) ? last_bin[AW-1:0] : quot[AW-1:0];

endmodule

@@ src/linear_bucket_histogram_core.sv @@
// linear_bucket_histogram_core: equal-width bin histogram with one count memory
// flow: a sample or read passes through S_BIN and S_RMW into the output register, a dropped sample
// or opcode 3 goes through S_DONE, a clear sweeps the count memory and then replies from S_DONE;
// one item at a time: the next is taken only back in S_IDLE, once the result has loaded
// reset: clearing pass over the count memory, no input transfer taken
// meanwhile (configuration writes are taken); depends on lbh_pkg, lbh_bin_map
module linear_bucket_histogram_core #(
  parameter int BINS        = 256,
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_write_en,
  input  logic [lbh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lbh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lbh_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [SAMPLE_BITS-1:0]           in_sample_value,
  input  logic [lbh_pkg::INDEX_W-1:0]      in_bin_index,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_counted,
  output logic [lbh_pkg::INDEX_W-1:0]      out_bin_number,
  output logic [lbh_pkg::RESULT_W-1:0]     out_bin_value,
  output logic [lbh_pkg::RESULT_W-1:0]     out_peak_count
);
  import lbh_pkg::*;

  localparam int AW    = $clog2(BINS);
  localparam int CMP_W = (SAMPLE_BITS > RANGE_HIGH_W) ? SAMPLE_BITS : RANGE_HIGH_W;

  // configuration registers
  logic [RANGE_LOW_W-1:0]  range_low_r;
  logic [RANGE_HIGH_W-1:0] range_high_r;
  logic [TOTAL_W-1:0]      bin_total_r;
  logic [SCALE_W-1:0]      bin_scale_r;

  // controller
  state_t                  state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic                    clr_reply_r;
  logic                    clr_last;
  logic                    in_fire;
  logic                    out_free;

  // item held while it is worked on
  opcode_t                 op_r;
  logic [INDEX_W-1:0]      idx_r;
  logic                    hit_r;
  logic [AW-1:0]           addr_r;

  // front-end decode
  logic [CMP_W-1:0]        sample_ext;
  logic                    in_range;
  logic [DIFF_W-1:0]       sample_diff;
  logic [AW-1:0]           map_bin;
  logic [AW-1:0]           idx_addr;
  logic                    idx_oob;

  // count memory, registered read
  logic [COUNT_BITS-1:0]   count_mem [BINS];
  logic [COUNT_BITS-1:0]   ram_rdata_r;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [COUNT_BITS-1:0]   ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;

  // update path
  logic [COUNT_BITS-1:0]   count_inc;
  logic [COUNT_BITS-1:0]   peak_r, peak_nxt;

  // output register
  logic                    out_valid_r;
  logic                    out_counted_r;
  logic [INDEX_W-1:0]      out_bin_number_r;
  logic [RESULT_W-1:0]     out_bin_value_r;
  logic [RESULT_W-1:0]     out_peak_count_r;
  logic                    out_load;
  logic                    load_counted;
  logic [INDEX_W-1:0]      load_number;
  logic [RESULT_W-1:0]     load_value;
  logic [RESULT_W-1:0]     load_peak;

  // handshakes: one item at a time, the output slot frees on a result transfer
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // range test, an empty range drops everything
  assign sample_ext  = CMP_W'(in_sample_value);
  assign in_range    = (sample_ext >= CMP_W'(range_low_r)) &&
                       (sample_ext <  CMP_W'(range_high_r));
  // offset fits 16 bits whenever the sample is inside the range
  assign sample_diff = DIFF_W'(sample_ext - CMP_W'(range_low_r));

  // scaled offset is multiplied on the transfer edge, clamped in the next state
  lbh_bin_map #(
    .BINS (BINS)
  ) u_bin_map (
    .clk       (clk),
    .load      (in_fire),
    .diff      (sample_diff),
    .scale     (bin_scale_r),
    .bin_total (bin_total_r),
    .bin       (map_bin)
  );

  // read address of a bin read, indexes past the storage read as zero
  assign idx_addr = AW'(idx_r);
  assign idx_oob  = (32'(idx_r) >= BINS);

  // saturating increment of the fetched count
  assign count_inc = (ram_rdata_r == '1) ? ram_rdata_r : ram_rdata_r + COUNT_BITS'(1);

  assign clr_last = (clr_cnt_r == AW'(BINS - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
      bin_total_r  <= BIN_TOTAL_RST;
      bin_scale_r  <= BIN_SCALE_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_RANGE_LOW:  range_low_r  <= cfg_wdata[RANGE_LOW_W-1:0];
        CFG_RANGE_HIGH: range_high_r <= cfg_wdata[RANGE_HIGH_W-1:0];
        CFG_BIN_TOTAL:  bin_total_r  <= cfg_wdata[TOTAL_W-1:0];
        CFG_BIN_SCALE:  bin_scale_r  <= cfg_wdata[SCALE_W-1:0];
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          priority if (in_opcode == OP_SAMPLE && in_range) begin
            state_nxt = S_BIN;
          end else if (in_opcode == OP_READ) begin
            state_nxt = S_BIN;
          end else if (in_opcode == OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else begin
            // dropped sample or opcode 3
            state_nxt = S_DONE;
          end
        end
      end
      S_BIN: begin
        state_nxt = S_RMW;
      end
      S_RMW, S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // memory control, update and result assembly
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = clr_cnt_r;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = map_bin;
    clr_cnt_nxt  = clr_cnt_r;
    peak_nxt     = peak_r;
    out_load     = 1'b0;
    load_counted = 1'b0;
    load_number  = '0;
    load_value   = '0;
    load_peak    = RESULT_W'(peak_r);
    unique case (state_r)
      S_CLEAR: begin
        // sweep writes zero, one entry a cycle
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      S_IDLE: begin
      end
      S_BIN: begin
        ram_re    = 1'b1;
        ram_raddr = (op_r == OP_READ) ? idx_addr : map_bin;
      end
      S_RMW: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hit_r) begin
            ram_we       = 1'b1;
            ram_waddr    = addr_r;
            ram_wdata    = count_inc;
            peak_nxt     = (count_inc > peak_r) ? count_inc : peak_r;
            load_counted = 1'b1;
            load_number  = INDEX_W'(addr_r);
            load_value   = RESULT_W'(count_inc);
            load_peak    = RESULT_W'(peak_nxt);
          end else begin
            load_number  = idx_r;
            load_value   = idx_oob ? '0 : RESULT_W'(ram_rdata_r);
          end
        end
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (in_fire) begin
        clr_reply_r <= (in_opcode == OP_CLEAR);
      end
      if (in_fire && in_opcode == OP_CLEAR) begin
        peak_r <= '0;
      end else begin
        peak_r <= peak_nxt;
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_opcode;
      idx_r <= in_bin_index;
      hit_r <= (in_opcode == OP_SAMPLE) && in_range;
    end
    if (state_r == S_BIN) begin
      addr_r <= ram_raddr;
    end
  end

  // count memory: read data holds until the next read
  always_ff @(posedge clk) begin
    if (ram_we) begin
      count_mem[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      ram_rdata_r <= count_mem[ram_raddr];
    end
  end

  // output register, a new result may load in the cycle the old one transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_counted_r    <= load_counted;
      out_bin_number_r <= load_number;
      out_bin_value_r  <= load_value;
      out_peak_count_r <= load_peak;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_counted    = out_counted_r;
  assign out_bin_number = out_bin_number_r;
  assign out_bin_value  = out_bin_value_r;
  assign out_peak_count = out_peak_count_r;

  // a clear transfer always starts the sweep
  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_CLEAR) |=> (state_r == S_CLEAR && clr_cnt_r == '0))
    else $error("clear transfer did not start the clearing sweep");

  // a counted sample always leaves a nonzero count
  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_counted_r) |-> (COUNT_BITS > RESULT_W || out_bin_value_r != '0))
    else $error("counted sample reported a zero bin count");

  // the peak covers the bin just counted
  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_counted_r) |->
      (COUNT_BITS > RESULT_W || out_peak_count_r >= out_bin_value_r))
    else $error("peak count below the counted bin");

  // the count memory is only written by the sweep or an update
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || (state_r == S_RMW && hit_r && out_free)))
    else $error("count memory written outside sweep or update");

endmodule

@@ verif/linear_bucket_histogram_checker.sv @@
`timescale 1ns / 100ps
// linear_bucket_histogram_checker: predicts and checks every result of the histogram core
// watches the config port and both channels; depends on lbh_pkg
module linear_bucket_histogram_checker #(
  parameter int BINS        = 256,
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write_en,
  input  logic [lbh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lbh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [lbh_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [SAMPLE_BITS-1:0]           in_sample_value,
  input  logic [lbh_pkg::INDEX_W-1:0]      in_bin_index,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_counted,
  input  logic [lbh_pkg::INDEX_W-1:0]      out_bin_number,
  input  logic [lbh_pkg::RESULT_W-1:0]     out_bin_value,
  input  logic [lbh_pkg::RESULT_W-1:0]     out_peak_count,
  output int unsigned                      fail_count,
  output int unsigned                      open_count
);
  import lbh_pkg::*;

  typedef struct packed {
    logic                counted;
    logic [INDEX_W-1:0]  bin_number;
    logic [RESULT_W-1:0] bin_value;
    logic [RESULT_W-1:0] peak_count;
  } hist_result_t;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam int unsigned REPORT_LIMIT = 40;

  // private copy of the histogram state and registers
  logic [COUNT_BITS-1:0]   tally [BINS];
  logic [COUNT_BITS-1:0]   peak_tally;
  logic [RANGE_LOW_W-1:0]  lo_bound;
  logic [RANGE_HIGH_W-1:0] hi_bound;
  logic [TOTAL_W-1:0]      active_total;
  logic [SCALE_W-1:0]      scale_q16;

  hist_result_t pending_results[$];
  hist_result_t want;
  int unsigned  result_seq;

  initial begin
    fail_count = 0;
    open_count = 0;
    result_seq = 0;
  end

  task report_failure(input string msg);
    if (fail_count < REPORT_LIMIT)
      $display("%0t ns histogram check: %s", $time, msg);
    fail_count++;
  endtask

  function int unsigned bins_in_use();
    if (active_total == 0)
      return 1;
    if (active_total > BINS)
      return BINS;
    return active_total;
  endfunction

  // applies one operation to the private state and returns the result it gives
  function hist_result_t histogram_update(input logic [OPCODE_W-1:0] op,
                                          input logic [SAMPLE_BITS-1:0] value,
                                          input logic [INDEX_W-1:0] index);
    hist_result_t r;
    logic [63:0]  scaled;
    int unsigned  slot;
    r = '0;
    case (op)
      OP_SAMPLE: begin
        if (value >= lo_bound && value < hi_bound) begin
          scaled = ((64'(value) - 64'(lo_bound)) * 64'(scale_q16)) >> FRAC_W;
          if (scaled > 64'(bins_in_use() - 1))
            slot = bins_in_use() - 1;
          else
            slot = int'(scaled);
          if (tally[slot] != COUNT_TOP)
            tally[slot] = tally[slot] + 1'b1;
          if (tally[slot] > peak_tally)
            peak_tally = tally[slot];
          r.counted    = 1'b1;
          r.bin_number = INDEX_W'(slot);
          r.bin_value  = RESULT_W'(tally[slot]);
        end
      end
      OP_READ: begin
        r.bin_number = index;
        r.bin_value  = (index < BINS) ? RESULT_W'(tally[index]) : '0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < BINS; i++)
          tally[i] = '0;
        peak_tally = '0;
      end
      default: ;
    endcase
    r.peak_count = RESULT_W'(peak_tally);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BINS; i++)
        tally[i] = '0;
      peak_tally   = '0;
      lo_bound     = RANGE_LOW_RST;
      hi_bound     = RANGE_HIGH_RST;
      active_total = BIN_TOTAL_RST;
      scale_q16    = BIN_SCALE_RST;
      pending_results.delete();
    end else begin
      // results leave before the item of this edge is predicted
      if (out_valid && !out_stall) begin
        result_seq++;
        if (pending_results.size() == 0) begin
          report_failure($sformatf("result %0d arrived with nothing expected", result_seq));
        end else begin
          want = pending_results.pop_front();
          if (out_counted !== want.counted)
            report_failure($sformatf("result %0d counted %b, expected %b",
                                     result_seq, out_counted, want.counted));
          if (out_bin_number !== want.bin_number)
            report_failure($sformatf("result %0d bin_number %0d, expected %0d",
                                     result_seq, out_bin_number, want.bin_number));
          if (out_bin_value !== want.bin_value)
            report_failure($sformatf("result %0d bin_value %0d, expected %0d",
                                     result_seq, out_bin_value, want.bin_value));
          if (out_peak_count !== want.peak_count)
            report_failure($sformatf("result %0d peak_count %0d, expected %0d",
                                     result_seq, out_peak_count, want.peak_count));
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_RANGE_LOW:  lo_bound     = cfg_wdata[RANGE_LOW_W-1:0];
          CFG_RANGE_HIGH: hi_bound     = cfg_wdata[RANGE_HIGH_W-1:0];
          CFG_BIN_TOTAL:  active_total = cfg_wdata[TOTAL_W-1:0];
          CFG_BIN_SCALE:  scale_q16    = cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_results.push_back(histogram_update(in_opcode, in_sample_value, in_bin_index));
    end
    open_count = pending_results.size();
  end

endmodule

@@ verif/linear_bucket_histogram_core_test.sv @@
`timescale 1ns / 100ps
// linear_bucket_histogram_core_test: stimulus and verdict for the histogram core
// drives config, input and result channels; checking lives in linear_bucket_histogram_checker
// depends on lbh_pkg, linear_bucket_histogram_core, linear_bucket_histogram_checker
module linear_bucket_histogram_core_test;
  import lbh_pkg::*;

  localparam int BINS        = 256;
  localparam int COUNT_BITS  = 32;
  localparam int SAMPLE_BITS = 16;

  // longest idle draw per transfer, on either side
  localparam int unsigned MAX_GAP          = 18;
  // receiver hold-off long enough to back the core up into its input
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned RANDOM_PHASES    = 13;
  localparam int unsigned PHASE_ITEMS      = 100;
  // a clear takes a full pass over the count memory
  localparam int unsigned DRAIN_CYCLES     = BINS + 8;
  // run limit in ns, far beyond the slowest correct run
  localparam int unsigned RUN_LIMIT_NS     = 2_000_000;
  localparam logic [SCALE_W-1:0] SCALE_TOP = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index    = CFG_RANGE_LOW;
  logic [CFG_DATA_W-1:0]   cfg_wdata    = '0;

  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic [OPCODE_W-1:0]     in_opcode       = OP_NOP;
  logic [SAMPLE_BITS-1:0]  in_sample_value = '0;
  logic [INDEX_W-1:0]      in_bin_index    = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_counted;
  logic [INDEX_W-1:0]      out_bin_number;
  logic [RESULT_W-1:0]     out_bin_value;
  logic [RESULT_W-1:0]     out_peak_count;

  int unsigned fail_count;
  int unsigned open_count;

  // idle switches for each side, and the one-shot request for the long hold-off
  logic feed_idle     = 1'b1;
  logic sink_idle     = 1'b1;
  logic long_hold_req = 1'b0;

  linear_bucket_histogram_core #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (.*);

  linear_bucket_histogram_checker #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("linear_bucket_histogram_core_test failed");
    $finish;
  end

  // one input transfer: optional gap, then hold the item until it is taken
  task automatic send_item(input logic [OPCODE_W-1:0] op,
                           input logic [SAMPLE_BITS-1:0] value,
                           input logic [INDEX_W-1:0] index);
    int unsigned gap;
    gap = feed_idle ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_sample_value <= value;
    in_bin_index    <= index;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for every predicted result to come back
  // open_count is sampled on the falling edge to stay clear of the checker's update
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
    @(posedge clk);
  endtask

  // writes all four registers on back-to-back cycles once the core is idle
  task automatic set_config(input logic [RANGE_HIGH_W-1:0] low,
                            input logic [RANGE_HIGH_W-1:0] high,
                            input logic [TOTAL_W-1:0] total,
                            input logic [SCALE_W-1:0] scale);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_RANGE_LOW;
    cfg_wdata    <= CFG_DATA_W'(low);
    @(posedge clk);
    cfg_index    <= CFG_RANGE_HIGH;
    cfg_wdata    <= CFG_DATA_W'(high);
    @(posedge clk);
    cfg_index    <= CFG_BIN_TOTAL;
    cfg_wdata    <= CFG_DATA_W'(total);
    @(posedge clk);
    cfg_index    <= CFG_BIN_SCALE;
    cfg_wdata    <= CFG_DATA_W'(scale);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // result side: random stall per transfer, plus the long hold-off when asked
  initial begin : result_sink
    int unsigned hold;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else begin
        hold = sink_idle ? $urandom_range(MAX_GAP, 0) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int unsigned             phase;
    int unsigned             pick;
    int unsigned             mode;
    logic [RANGE_HIGH_W-1:0] lo;
    logic [RANGE_HIGH_W-1:0] hi;
    logic [TOTAL_W-1:0]      total;
    logic [SCALE_W-1:0]      scale;
    logic [63:0]             ratio;
    logic [SAMPLE_BITS-1:0]  value;
    logic [INDEX_W-1:0]      index;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full range, one bin per 256 values; the core is still in its clearing pass
    set_config(17'd0, 17'h10000, 9'd256, 25'd256);
    send_item(OP_SAMPLE, 16'h0000, 8'd0);
    send_item(OP_SAMPLE, 16'h0000, 8'd0);
    send_item(OP_SAMPLE, 16'hFFFF, 8'd0);
    send_item(OP_SAMPLE, 16'h8000, 8'd0);
    send_item(OP_READ,   16'h0000, 8'd0);
    send_item(OP_READ,   16'h0000, 8'd200);
    send_item(OP_NOP,    16'h0000, 8'd0);
    send_item(OP_READ,   16'h0000, 8'd255);

    // narrow window with four bins: drops at both bounds, clamp past the last bin,
    // then a read of a bin beyond the active ones that still holds a count
    set_config(17'd100, 17'd200, 9'd4, 25'h20000);
    send_item(OP_SAMPLE, 16'd99,  8'd0);
    send_item(OP_SAMPLE, 16'd200, 8'd0);
    send_item(OP_SAMPLE, 16'd100, 8'd0);
    send_item(OP_SAMPLE, 16'd101, 8'd0);
    send_item(OP_SAMPLE, 16'd150, 8'd0);
    send_item(OP_SAMPLE, 16'd199, 8'd0);
    send_item(OP_READ,   16'd0,   8'd255);

    // empty range drops everything
    set_config(17'd500, 17'd500, 9'd0, SCALE_TOP);
    send_item(OP_SAMPLE, 16'd500, 8'd0);
    send_item(OP_SAMPLE, 16'd0,   8'd0);

    // zero bin total acts as a single bin
    set_config(17'd0, 17'h10000, 9'd0, SCALE_TOP);
    send_item(OP_SAMPLE, 16'hFFFF, 8'd0);
    send_item(OP_SAMPLE, 16'd1,    8'd0);

    // bin total above the bin count saturates, large scale clamps to the top bin
    set_config(17'd0, 17'h10000, 9'd511, 25'h1000000);
    send_item(OP_SAMPLE, 16'd1,    8'd0);
    send_item(OP_SAMPLE, 16'd0,    8'd0);
    send_item(OP_CLEAR,  16'd0,    8'd0);
    send_item(OP_READ,   16'd0,    8'd0);
    send_item(OP_NOP,    16'd0,    8'd0);
    send_item(OP_SAMPLE, 16'hFFFF, 8'd0);

    // random phases, each with its own register setting and idle pattern
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = (phase < 6) ? phase : $urandom_range(5, 0);
      case (mode)
        0: begin
          lo = '0; hi = 17'h10000; total = 9'd256; scale = 25'd256;
        end
        1: begin
          // consistent window: scale matches bin total over range width
          lo    = RANGE_HIGH_W'($urandom_range(60000, 0));
          hi    = RANGE_HIGH_W'($urandom_range(65536, lo + 1));
          total = TOTAL_W'($urandom_range(256, 1));
          ratio = (64'(total) << FRAC_W) / 64'(hi - lo);
          scale = SCALE_W'(ratio);
        end
        2: begin
          // tiny hot window so a few bins count up high
          lo = RANGE_HIGH_W'($urandom_range(65535, 0));
          hi = RANGE_HIGH_W'(lo + $urandom_range(40, 1));
          if (hi > 17'h10000)
            hi = 17'h10000;
          total = TOTAL_W'($urandom_range(8, 1));
          ratio = (64'(total) << FRAC_W) / 64'(hi - lo);
          scale = SCALE_W'(ratio);
        end
        3: begin
          lo = '0; hi = 17'h10000;
          total = TOTAL_W'($urandom_range(511, 257));
          scale = SCALE_W'($urandom);
        end
        4: begin
          // empty or inverted range
          lo    = RANGE_HIGH_W'($urandom_range(65535, 0));
          hi    = RANGE_HIGH_W'($urandom_range(lo, 0));
          total = 9'd0;
          scale = '0;
        end
        default: begin
          lo    = RANGE_HIGH_W'($urandom_range(65535, 0));
          hi    = RANGE_HIGH_W'($urandom_range(65536, 0));
          total = TOTAL_W'($urandom);
          scale = SCALE_W'($urandom);
        end
      endcase
      set_config(lo, hi, total, scale);

      case (phase % 4)
        0: begin feed_idle = 1'b1; sink_idle = 1'b1; end
        1: begin feed_idle = 1'b0; sink_idle = 1'b0; end
        2: begin feed_idle = 1'b1; sink_idle = 1'b0; end
        default: begin feed_idle = 1'b0; sink_idle = 1'b1; end
      endcase
      // back-pressure burst: receiver holds off while the sender keeps offering
      if (phase == 2) begin
        feed_idle     = 1'b0;
        long_hold_req = 1'b1;
      end

      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        if (hi > lo && $urandom_range(3, 0) != 0)
          value = SAMPLE_BITS'($urandom_range(hi - 1, lo));
        else
          value = SAMPLE_BITS'($urandom);
        index = $urandom_range(1, 0) ? INDEX_W'($urandom_range(7, 0)) : INDEX_W'($urandom);
        if (pick < 78)
          send_item(OP_SAMPLE, value, index);
        else if (pick < 92)
          send_item(OP_READ, value, index);
        else if (pick < 97)
          send_item(OP_NOP, value, index);
        else
          send_item(OP_CLEAR, value, index);
      end
    end

    // drain and let any late result show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("linear_bucket_histogram_core_test passed");
    end else begin
      $display("linear_bucket_histogram_core_test failed");
    end
    $finish;
  end

endmodule
